[hw/rtl/sdsc_pkg.sv]
// ----------------------------------------------------------------------------
// sdsc_pkg
// Shared types, constants and tables of the spreadsheet date serial converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdsc_pkg;

  localparam int unsigned SERIAL_W   = 22;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned MONTH_IN_W = 7;
  localparam int unsigned DAY_IN_W   = 7;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned DOY_W      = 9;
  localparam int unsigned Q100_W     = 8;

  localparam logic [YEAR_W-1:0]   FIRST_YEAR     = 14'd1900;
  localparam logic [YEAR_W-1:0]   LAST_YEAR      = 14'd9999;
  localparam logic [YEAR_W-1:0]   EPOCH_YEAR     = 14'd1600;
  localparam logic [SERIAL_W-1:0] SERIAL_MAX     = 22'd2958465;
  localparam logic [SERIAL_W-1:0] PHANTOM_SERIAL = 22'd60;
  // Day index counted from 1 March 1600; true day count d maps to d + EPOCH_OFFSET
  localparam logic [SERIAL_W-1:0] EPOCH_OFFSET   = 22'd109512;
  // Day index of 1 March 1900, the first date after the phantom leap day
  localparam logic [SERIAL_W-1:0] MARCH_1900_IDX = 22'd109572;

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = YEAR_W + 13;

  localparam int unsigned STEP_COUNT = 14;
  localparam int unsigned STEP_W     = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'(STEP_COUNT - 1);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 3'd0,
    STATUS_BAD_MONTH    = 3'd1,
    STATUS_BAD_DAY      = 3'd2,
    STATUS_YEAR_RANGE   = 3'd3,
    STATUS_SERIAL_RANGE = 3'd4
  } status_t;

  typedef enum logic {
    REQ_TO_SERIAL = 1'b0,
    REQ_TO_DATE   = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP,
    ST_CHECK,
    ST_STEP,
    ST_MONTH,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic              load_in;
    logic              leap;
    logic              check;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              month;
    logic              load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic to_date;
    logic chk_err;
  } dp_sts_t;

  // Mixed-radix digit weights in days: 400-year eras, centuries, 4-year blocks, years
  function automatic logic [SERIAL_W-1:0] step_days(input logic [STEP_W-1:0] idx);
    logic [SERIAL_W-1:0] d;
    unique case (idx)
      4'd0:    d = 22'd2337552;
      4'd1:    d = 22'd1168776;
      4'd2:    d = 22'd584388;
      4'd3:    d = 22'd292194;
      4'd4:    d = 22'd146097;
      4'd5:    d = 22'd73048;
      4'd6:    d = 22'd36524;
      4'd7:    d = 22'd23376;
      4'd8:    d = 22'd11688;
      4'd9:    d = 22'd5844;
      4'd10:   d = 22'd2922;
      4'd11:   d = 22'd1461;
      4'd12:   d = 22'd730;
      4'd13:   d = 22'd365;
      default: d = '0;
    endcase
    return d;
  endfunction

  // Same digits in years
  function automatic logic [YEAR_W-1:0] step_years(input logic [STEP_W-1:0] idx);
    logic [YEAR_W-1:0] y;
    unique case (idx)
      4'd0:    y = 14'd6400;
      4'd1:    y = 14'd3200;
      4'd2:    y = 14'd1600;
      4'd3:    y = 14'd800;
      4'd4:    y = 14'd400;
      4'd5:    y = 14'd200;
      4'd6:    y = 14'd100;
      4'd7:    y = 14'd64;
      4'd8:    y = 14'd32;
      4'd9:    y = 14'd16;
      4'd10:   y = 14'd8;
      4'd11:   y = 14'd4;
      4'd12:   y = 14'd2;
      4'd13:   y = 14'd1;
      default: y = '0;
    endcase
    return y;
  endfunction

  // Length of a calendar month in a common year
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
      4'd2:                                      n = 5'd28;
      default:                                   n = 5'd0;
    endcase
    return n;
  endfunction

  // Days before month mp of a year that starts in March (mp 0 = March)
  function automatic logic [DOY_W-1:0] march_cum(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] c;
    unique case (mp)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd61;
      4'd3:    c = 9'd92;
      4'd4:    c = 9'd122;
      4'd5:    c = 9'd153;
      4'd6:    c = 9'd184;
      4'd7:    c = 9'd214;
      4'd8:    c = 9'd245;
      4'd9:    c = 9'd275;
      4'd10:   c = 9'd306;
      4'd11:   c = 9'd337;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/spreadsheet_date_serial_converter_top.sv]
// ----------------------------------------------------------------------------
// spreadsheet_date_serial_converter_top
// Converts dates to 1900-system serial day numbers and back.
//
// The request channel (in_valid / in_ready) carries req_type and either a
// date (year_in, month_in, day_in) or serial_in. The result channel
// (out_valid / out_ready) carries serial_out, year_out, month_out, day_out
// and status; each request gives exactly one result.
// One request is worked on at a time; in_ready is high only when the block
// is idle. A request passes through the leap, check, digit-step, month
// (serial to date only) and finish states before its result is loaded; a
// failed check goes straight to finish. The next request is taken once the
// sequencer is back in idle. The shared compare-subtract unit works through
// 14 digit steps (400-year eras, centuries, 4-year blocks, years).
// The result sits in an output register: while the receiver stalls, the
// next request is taken and worked on, and only its final load waits for
// the output register to drain. Reset returns the sequencer to idle and
// drops out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spreadsheet_date_serial_converter_top
  import sdsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [YEAR_W-1:0]     year_in,
  input  logic [MONTH_IN_W-1:0] month_in,
  input  logic [DAY_IN_W-1:0]   day_in,
  input  logic [SERIAL_W-1:0]   serial_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SERIAL_W-1:0]   serial_out,
  output logic [YEAR_W-1:0]     year_out,
  output logic [MONTH_W-1:0]    month_out,
  output logic [DAY_W-1:0]      day_out,
  output logic [STATUS_W-1:0]   status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sdsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdsc_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req_type),
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .serial_in  (serial_in),
    .serial_out (serial_out),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .status     (status)
  );

endmodule

`default_nettype wire

[hw/rtl/sdsc_ctrl.sv]
// ----------------------------------------------------------------------------
// sdsc_ctrl
// Sequencer of the converter: handshakes, step counter and datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdsc_ctrl
  import sdsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              out_valid_next;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LEAP;
      ST_LEAP:   state_next = ST_CHECK;
      ST_CHECK:  state_next = sts.chk_err ? ST_FINISH : ST_STEP;
      ST_STEP: begin
        if (step_cnt == STEP_LAST) state_next = sts.to_date ? ST_MONTH : ST_FINISH;
      end
      ST_MONTH:  state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step_idx  = step_cnt;
    step_cnt_next = step_cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_LEAP:  cmd.leap = 1'b1;
      ST_CHECK: begin
        cmd.check     = 1'b1;
        step_cnt_next = '0;
      end
      ST_STEP: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
      end
      ST_MONTH:  cmd.month = 1'b1;
      ST_FINISH: cmd.load_out = slot_free;
      default:   cmd = '0;
    endcase
  end

  // Hold the result until the transfer, reload when a new one is ready
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sdsc_dp.sv]
// ----------------------------------------------------------------------------
// sdsc_dp
// Datapath: request registers, validity checks, shared compare-subtract
// digit unit, month lookup and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdsc_dp
  import sdsc_pkg::*;
(
  input  logic                  clk,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  req_type,
  input  logic [YEAR_W-1:0]     year_in,
  input  logic [MONTH_IN_W-1:0] month_in,
  input  logic [DAY_IN_W-1:0]   day_in,
  input  logic [SERIAL_W-1:0]   serial_in,
  output logic [SERIAL_W-1:0]   serial_out,
  output logic [YEAR_W-1:0]     year_out,
  output logic [MONTH_W-1:0]    month_out,
  output logic [DAY_W-1:0]      day_out,
  output logic [STATUS_W-1:0]   status
);

  req_t                  req_r;
  logic [YEAR_W-1:0]     year_r;
  logic [MONTH_IN_W-1:0] month_r;
  logic [DAY_IN_W-1:0]   day_r;
  logic [SERIAL_W-1:0]   serial_r;
  logic [Q100_W-1:0]     q100;
  logic [SERIAL_W-1:0]   src;
  logic [SERIAL_W-1:0]   acc;
  status_t               wk_status;
  logic                  zero_day;
  logic [MONTH_W-1:0]    wk_month;
  logic [DAY_W-1:0]      wk_day;
  status_t               out_status;

  logic [PROD_W-1:0]   prod;
  logic [YEAR_W-1:0]   hundreds;
  logic                div100, leap, month_ok;
  logic [DAY_W-1:0]    mlen;
  status_t             chk_status;
  logic [YEAR_W-1:0]   march_year;
  logic [MONTH_W-1:0]  mp_fwd;
  logic [DOY_W-1:0]    fwd_doy;
  logic [SERIAL_W-1:0] true_day;
  logic [SERIAL_W-1:0] cmp_val, add_val;
  logic [DOY_W-1:0]    doy;
  logic [MONTH_W-1:0]  mp_rev;
  logic [DOY_W-1:0]    rev_day;
  logic [SERIAL_W-1:0] fwd_serial;

  assign prod = PROD_W'(year_r) * PROD_W'(RECIP_100);

  // Leap year from the registered year / 100
  always_comb begin
    hundreds = YEAR_W'(q100) * 14'd100;
    div100   = (hundreds == year_r);
    leap     = div100 ? (q100[1:0] == 2'b00) : (year_r[1:0] == 2'b00);
    month_ok = (month_r >= 7'd1) && (month_r <= 7'd12);
    mlen     = month_len(month_r[MONTH_W-1:0]) +
               DAY_W'(month_r == 7'd2 && leap);
  end

  always_comb begin
    if (req_r == REQ_TO_DATE) begin
      chk_status = (serial_r > SERIAL_MAX) ? STATUS_SERIAL_RANGE : STATUS_OK;
    end else begin
      priority if (!month_ok) begin
        chk_status = STATUS_BAD_MONTH;
      end else if (day_r == '0 || day_r > DAY_IN_W'(mlen)) begin
        chk_status = STATUS_BAD_DAY;
      end else if (year_r < FIRST_YEAR || year_r > LAST_YEAR) begin
        chk_status = STATUS_YEAR_RANGE;
      end else begin
        chk_status = STATUS_OK;
      end
    end
  end

  assign sts.to_date = (req_r == REQ_TO_DATE);
  assign sts.chk_err = (chk_status != STATUS_OK);

  // Years and months counted from March, so the leap day ends the year
  always_comb begin
    march_year = year_r - YEAR_W'(month_r <= 7'd2);
    mp_fwd     = (month_r >= 7'd3) ? MONTH_W'(month_r - 7'd3) : MONTH_W'(month_r + 7'd9);
    fwd_doy    = march_cum(mp_fwd) + DOY_W'(day_r) - 9'd1;
    true_day   = serial_r - SERIAL_W'(serial_r > PHANTOM_SERIAL);
  end

  // One digit per step: weights in days for serial to date, years otherwise
  always_comb begin
    if (req_r == REQ_TO_DATE) begin
      cmp_val = step_days(cmd.step_idx);
      add_val = SERIAL_W'(step_years(cmd.step_idx));
    end else begin
      cmp_val = SERIAL_W'(step_years(cmd.step_idx));
      add_val = step_days(cmd.step_idx);
    end
  end

  always_comb begin
    doy    = src[DOY_W-1:0];
    mp_rev = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= march_cum(MONTH_W'(k))) mp_rev = MONTH_W'(k);
    end
    rev_day = doy - march_cum(mp_rev) + 9'd1;
  end

  // Add the phantom leap day from 1 March 1900 on
  assign fwd_serial = (acc >= MARCH_1900_IDX) ? acc - (EPOCH_OFFSET - 22'd1)
                                              : acc - EPOCH_OFFSET;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r    <= req_t'(req_type);
      year_r   <= year_in;
      month_r  <= month_in;
      day_r    <= day_in;
      serial_r <= serial_in;
    end
    if (cmd.leap) begin
      q100 <= prod[PROD_W-1:RECIP_SHIFT];
    end
    if (cmd.check) begin
      wk_status <= chk_status;
      zero_day  <= (serial_r == '0);
      if (req_r == REQ_TO_DATE) begin
        src <= true_day + EPOCH_OFFSET;
        acc <= SERIAL_W'(EPOCH_YEAR);
      end else begin
        src <= SERIAL_W'(march_year - EPOCH_YEAR);
        acc <= SERIAL_W'(fwd_doy);
      end
    end
    if (cmd.step && src >= cmp_val) begin
      src <= src - cmp_val;
      acc <= acc + add_val;
    end
    if (cmd.month) begin
      if (zero_day) begin
        acc      <= SERIAL_W'(FIRST_YEAR);
        wk_month <= 4'd1;
        wk_day   <= '0;
      end else begin
        acc      <= acc + SERIAL_W'(mp_rev >= 4'd10);
        wk_month <= (mp_rev < 4'd10) ? mp_rev + 4'd3 : mp_rev - 4'd9;
        wk_day   <= rev_day[DAY_W-1:0];
      end
    end
    if (cmd.load_out) begin
      out_status <= wk_status;
      serial_out <= '0;
      year_out   <= '0;
      month_out  <= '0;
      day_out    <= '0;
      if (wk_status == STATUS_OK) begin
        if (req_r == REQ_TO_DATE) begin
          year_out  <= acc[YEAR_W-1:0];
          month_out <= wk_month;
          day_out   <= wk_day;
        end else begin
          serial_out <= fwd_serial;
        end
      end
    end
  end

  assign status = out_status;

endmodule

`default_nettype wire

[hw/rtl/sdsc_checker.sv]
// ----------------------------------------------------------------------------
// sdsc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdsc_checker
  import sdsc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SERIAL_W-1:0] serial_out,
  input logic [YEAR_W-1:0]   year_out,
  input logic [MONTH_W-1:0]  month_out,
  input logic [DAY_W-1:0]    day_out,
  input logic [STATUS_W-1:0] status
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(serial_out) && $stable(year_out)
      && $stable(month_out) && $stable(day_out) && $stable(status))
    else $error("result changed while stalled");

  // One request in flight: no second transfer right after one
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // A failed request carries nothing but its status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> serial_out == '0 && year_out == '0
      && month_out == '0 && day_out == '0)
    else $error("error result with nonzero fields");

  // A result is either a serial or a date, never both
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> serial_out == '0 || (year_out == '0 && month_out == '0 && day_out == '0))
    else $error("serial and date fields both set");

endmodule

bind spreadsheet_date_serial_converter_top sdsc_checker u_sdsc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .serial_out (serial_out),
  .year_out   (year_out),
  .month_out  (month_out),
  .day_out    (day_out),
  .status     (status)
);

`default_nettype wire
